// File: rtl/core/simple_path_enumerator_assert.svh
// assertion macros for the simple path enumerator
`ifndef SIMPLE_PATH_ENUMERATOR_ASSERT_SVH
`define SIMPLE_PATH_ENUMERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SPE_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed: same cycle implication");
`define SPE_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed: next cycle implication");
`else
`define SPE_ASSERT_SAME(label, clk, rst_n, cond, expr)
`define SPE_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

// File: rtl/core/spe_pkg.sv
// shared types and constants for the simple path enumerator
package spe_pkg;

    localparam int SLOTS      = 6;
    localparam int NODE_COUNT = 6;
    localparam int MAX_PATHS  = 64;
    localparam int NODES      = (NODE_COUNT < SLOTS) ? NODE_COUNT : SLOTS;
    localparam int NODE_W     = 3;
    localparam int ROW_W      = 6;
    localparam int DEPTH_W    = 3;
    localparam int CFG_IDX_W  = 3;

    localparam logic [ROW_W-1:0] ADJ_RESET [SLOTS] = '{
        6'd50, 6'd37, 6'd42, 6'd52, 6'd41, 6'd31
    };

    typedef struct packed {
        logic [NODE_W-1:0] start_node;
        logic [NODE_W-1:0] end_node;
    } t_item;

    typedef struct packed {
        logic [2:0]        path_len;
        logic [NODE_W-1:0] node_0;
        logic [NODE_W-1:0] node_1;
        logic [NODE_W-1:0] node_2;
        logic [NODE_W-1:0] node_3;
        logic [NODE_W-1:0] node_4;
        logic [NODE_W-1:0] node_5;
        logic              truncated;
        logic              last_path;
    } t_result;

    typedef struct packed {
        logic init;
        logic step;
        logic finish;
        logic trunc;
        logic load_pend;
    } t_cmd;

    typedef struct packed {
        logic exhausted;
        logic hit;
        logic at_limit;
    } t_stat;

endpackage

// File: rtl/core/spe_ctrl.sv
// search controller state machine for the simple path enumerator
module spe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  spe_pkg::t_stat i_stat,
    output spe_pkg::t_cmd  o_cmd
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_SEARCH = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.init = 1'b1;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_stat.exhausted) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_stat.hit) begin
                    if (i_stat.at_limit) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.trunc  = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.load_pend = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state == S_SEARCH);

endmodule

// File: rtl/core/spe_datapath.sv
// search stack, adjacency registers and result registers
module spe_datapath #(
    parameter int MAX_PATHS = spe_pkg::MAX_PATHS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  spe_pkg::t_item                   i_item,
    input  logic                             i_cfg_valid,
    input  logic [spe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [spe_pkg::ROW_W-1:0]        i_cfg_data,
    input  spe_pkg::t_cmd                    i_cmd,
    output spe_pkg::t_stat                   o_stat,
    output logic                             o_strobe,
    output spe_pkg::t_result                 o_result
);

    localparam int CNT_W = $clog2(MAX_PATHS + 1);

    logic [spe_pkg::ROW_W-1:0]   r_adj    [spe_pkg::SLOTS];
    logic [spe_pkg::NODE_W-1:0]  r_stack  [spe_pkg::SLOTS];
    logic [spe_pkg::DEPTH_W-1:0] r_cursor [spe_pkg::SLOTS];
    logic [spe_pkg::DEPTH_W-1:0] r_depth;
    logic [spe_pkg::ROW_W-1:0]   r_mask;
    logic [spe_pkg::NODE_W-1:0]  r_end;
    logic [CNT_W-1:0]            r_count;
    spe_pkg::t_result            r_pend;
    logic                        r_pend_v;
    logic                        r_strobe;
    spe_pkg::t_result            r_result;

    logic [spe_pkg::DEPTH_W-1:0] top;
    logic [spe_pkg::NODE_W-1:0]  v;
    logic [spe_pkg::ROW_W-1:0]   row;
    logic [spe_pkg::DEPTH_W-1:0] cur;
    logic [spe_pkg::ROW_W-1:0]   cand;
    logic                        found;
    logic [spe_pkg::NODE_W-1:0]  j_sel;
    logic                        exhausted;
    logic                        hit;
    logic [spe_pkg::NODE_W-1:0]  nodes [spe_pkg::SLOTS];
    spe_pkg::t_result            path;
    spe_pkg::t_result            single;
    spe_pkg::t_result            word_out;
    logic                        in_range;

    assign top       = r_depth - 1'b1;
    assign v         = r_stack[top];
    assign row       = r_adj[v];
    assign cur       = r_cursor[top];
    assign exhausted = (r_depth == '0);

    always_comb begin
        for (int j = 0; j < spe_pkg::SLOTS; j++) begin
            cand[j] = row[j] && !r_mask[j] && (3'(j) >= cur) && (j < spe_pkg::NODES);
        end
        found = |cand;
        j_sel = '0;
        for (int j = spe_pkg::SLOTS - 1; j >= 0; j--) begin
            if (cand[j]) begin
                j_sel = 3'(j);
            end
        end
    end

    assign hit = !exhausted && found && (j_sel == r_end);

    always_comb begin
        for (int k = 0; k < spe_pkg::SLOTS; k++) begin
            if (3'(k) < r_depth) begin
                nodes[k] = r_stack[k];
            end else if (3'(k) == r_depth) begin
                nodes[k] = r_end;
            end else begin
                nodes[k] = '0;
            end
        end
        path           = '0;
        path.path_len  = r_depth + 1'b1;
        path.node_0    = nodes[0];
        path.node_1    = nodes[1];
        path.node_2    = nodes[2];
        path.node_3    = nodes[3];
        path.node_4    = nodes[4];
        path.node_5    = nodes[5];
        single         = '0;
        single.path_len = 3'd1;
        single.node_0  = i_item.start_node;
    end

    always_comb begin
        word_out           = r_pend_v ? r_pend : '0;
        word_out.truncated = i_cmd.trunc;
        word_out.last_path = i_cmd.finish;
    end

    assign in_range = (i_item.start_node < 3'(spe_pkg::NODES))
                   && (i_item.end_node < 3'(spe_pkg::NODES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < spe_pkg::SLOTS; i++) begin
                r_adj[i]    <= spe_pkg::ADJ_RESET[i];
                r_cursor[i] <= '0;
            end
            r_depth  <= '0;
            r_mask   <= '0;
            r_count  <= '0;
            r_pend_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_valid && (i_cfg_index < 3'(spe_pkg::SLOTS))) begin
                r_adj[i_cfg_index] <= i_cfg_data;
            end
            r_strobe <= i_cmd.finish || (i_cmd.load_pend && r_pend_v);
            if (i_cmd.init) begin
                r_end       <= i_item.end_node;
                r_count     <= '0;
                r_stack[0]  <= i_item.start_node;
                r_cursor[0] <= '0;
                r_pend      <= single;
                if (in_range && (i_item.start_node != i_item.end_node)) begin
                    r_depth  <= 3'd1;
                    r_mask   <= spe_pkg::ROW_W'(1) << i_item.start_node;
                    r_pend_v <= 1'b0;
                end else begin
                    r_depth  <= '0;
                    r_mask   <= '0;
                    r_pend_v <= in_range;
                end
            end else begin
                if (i_cmd.step && !exhausted) begin
                    if (!found) begin
                        r_mask  <= r_mask & ~(spe_pkg::ROW_W'(1) << v);
                        r_depth <= r_depth - 1'b1;
                    end else begin
                        r_cursor[top] <= j_sel + 3'd1;
                        if ((j_sel != r_end) && (r_depth < 3'(spe_pkg::SLOTS))) begin
                            r_stack[r_depth]  <= j_sel;
                            r_cursor[r_depth] <= '0;
                            r_mask            <= r_mask | (spe_pkg::ROW_W'(1) << j_sel);
                            r_depth           <= r_depth + 1'b1;
                        end
                    end
                end
                if (i_cmd.load_pend) begin
                    r_pend   <= path;
                    r_pend_v <= 1'b1;
                    r_count  <= r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish || i_cmd.load_pend) begin
            r_result <= word_out;
        end
    end

    assign o_stat.exhausted = exhausted;
    assign o_stat.hit       = hit;
    assign o_stat.at_limit  = (r_count == CNT_W'(MAX_PATHS));
    assign o_strobe         = r_strobe;
    assign o_result         = r_result;

endmodule

// File: rtl/core/simple_path_enumerator.sv
// top level of the simple path enumerator
// usage:
// raise i_start with a start and end node on i_item while o_busy is low; the word is
// taken at that edge and o_busy stays high until the final result has been decided.
// every simple path from start to end comes out on o_result, one word per path in
// depth-first order (lowest neighbour first), each marked by o_strobe for one cycle.
// the last word of an item has last_path set; with no path it is a single zero-length
// word, with start equal to end the one-node path.
// after MAX_PATHS paths the search stops and the last word carries truncated when a
// further path exists.
// the search loop advances one step at a time, each step a push, a pop or an end-node hit.
// results come one path behind the search, a new word at most every step cycle.
// the receiver cannot stall: a word is taken in the cycle its strobe is high.
// adjacency rows are to be written on the cfg channel (always ready) only while o_busy
// is low; the block itself does not enforce this. indexes past the last row are ignored.
// reset restores the default graph and leaves the block idle with no result pending.
`include "simple_path_enumerator_assert.svh"
module simple_path_enumerator #(
    parameter int MAX_PATHS = spe_pkg::MAX_PATHS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  spe_pkg::t_item                i_item,
    output logic                          o_strobe,
    output spe_pkg::t_result              o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [spe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [spe_pkg::ROW_W-1:0]     i_cfg_data
);

    spe_pkg::t_cmd  cmd;
    spe_pkg::t_stat stat;

    spe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    spe_datapath #(
        .MAX_PATHS (MAX_PATHS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    assign o_cfg_ready = 1'b1;

    `SPE_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `SPE_ASSERT_SAME(a_idle_on_last, i_clk, i_rst_n, o_strobe && o_result.last_path, !o_busy)
    `SPE_ASSERT_SAME(a_busy_on_mid, i_clk, i_rst_n, o_strobe && !o_result.last_path, o_busy)
    `SPE_ASSERT_SAME(a_trunc_is_last, i_clk, i_rst_n, o_strobe && o_result.truncated, o_result.last_path)
    `SPE_ASSERT_SAME(a_empty_is_last, i_clk, i_rst_n, o_strobe && (o_result.path_len == 3'd0), o_result.last_path)

endmodule
